// ===== src/idq_pkg.sv =====
package idq_pkg;

    // defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the command and result transactions
    localparam int CMD_W      = 3;
    localparam int PAYLOAD_W  = 32;
    localparam int POSITION_W = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_READ       = 3'd5
    } idq_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } idq_status_t;

    // broadcast from the control logic to every cell
    typedef struct packed {
        logic     commit;
        idq_cmd_t cmd;
    } idq_ctrl_t;

endpackage

// ===== src/indexed_deque.sv =====
// channel   | direction | ports                                   | handshake
// ----------+-----------+-----------------------------------------+--------------------
// command   | in        | s_cmd, s_payload_in, s_position         | s_valid / s_ready
// result    | out       | m_payload_out, m_status, m_count        | m_valid / m_ready
//
// one transaction per cycle unless m_ready stalls: every command finishes in the cycle
// it is accepted, its result lands in the output register and shows the next cycle
// the cell row shifts for push-front, pop-front and remove (from its position on);
// push-back writes one cell; the read port is an indexed select across the row
// aresetn (synchronous, active low) clears the element count and the output valid;
// cell contents are not reset and are only read below the count
// s_ready stays high while the output register is empty or being drained
module indexed_deque import idq_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [PAYLOAD_W-1:0]  s_payload_in,
    input  logic [POSITION_W-1:0] s_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PAYLOAD_W-1:0]  m_payload_out,
    output logic [STATUS_W-1:0]   m_status,
    output logic [COUNT_W-1:0]    m_count
);

    // stored word width: payload bits beyond DATA_WIDTH are dropped
    localparam int SW    = (DATA_WIDTH < PAYLOAD_W) ? DATA_WIDTH : PAYLOAD_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    // common width for comparing position against count
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [PAYLOAD_W-1:0] payload_out_reg;
    logic [PAYLOAD_W-1:0] payload_out_next;
    idq_status_t          status_reg;
    idq_status_t          status_next;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [COUNT_W-1:0]   m_count_next;

    logic                 accept;
    idq_cmd_t             cmd;
    logic [CMP_W-1:0]     pos_cmp;
    logic [CMP_W-1:0]     cnt_cmp;
    logic                 is_full;
    logic                 is_empty;
    logic                 in_range;
    idq_status_t          status;
    idq_ctrl_t            ctrl;
    logic [IDX_W-1:0]     pos_idx;
    logic [IDX_W-1:0]     rd_idx;
    logic [SW-1:0]        word;
    logic [SW-1:0]        read_word;

    logic [SW-1:0] cell_data [CAPACITY];
    logic [SW-1:0] cell_rd   [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = idq_cmd_t'(s_cmd);
    assign word    = s_payload_in[SW-1:0];

    assign pos_cmp  = CMP_W'(s_position);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign is_full  = (cnt_cmp == CAP_CMP);
    assign is_empty = (count_reg == '0);
    assign in_range = (pos_cmp < cnt_cmp);
    // only meaningful when in range, which keeps it below CAPACITY
    assign pos_idx  = IDX_W'(pos_cmp);

    // fault detection per command
    always_comb begin
        unique case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: status = is_full ? ST_FULL : ST_OK;
            CMD_REMOVE, CMD_READ:          status = in_range ? ST_OK : ST_RANGE;
            CMD_POP_BACK, CMD_POP_FRONT:   status = is_empty ? ST_EMPTY : ST_OK;
            default:                       status = ST_OK;
        endcase
    end

    // which cell drives the read bus
    always_comb begin
        unique case (cmd)
            CMD_POP_BACK:  rd_idx = IDX_W'(count_reg - CNT_W'(1));
            CMD_POP_FRONT: rd_idx = '0;
            default:       rd_idx = pos_idx;
        endcase
    end

    assign ctrl.commit = accept && (status == ST_OK);
    assign ctrl.cmd    = cmd;

    // the cell row: neighbors hand their registered words across directly
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [SW-1:0] left_d;
        logic [SW-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end

        idq_cell #(
            .INDEX (i),
            .SW    (SW),
            .CNT_W (CNT_W),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .pos        (pos_idx),
            .rd_idx     (rd_idx),
            .word       (word),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // each cell gates its word with its own select, so an OR collects the read
    always_comb begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_word = read_word | cell_rd[i];
        end
    end

    // count update and result assembly
    always_comb begin
        count_next       = count_reg;
        payload_out_next = '0;
        if (status == ST_OK) begin
            unique case (cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    count_next = count_reg + CNT_W'(1);
                end
                CMD_REMOVE, CMD_POP_BACK, CMD_POP_FRONT: begin
                    count_next       = count_reg - CNT_W'(1);
                    payload_out_next = PAYLOAD_W'(read_word);
                end
                CMD_READ: begin
                    payload_out_next = PAYLOAD_W'(read_word);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign status_next  = status;
    assign m_count_next = COUNT_W'(count_next);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, status and count, loaded with each accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            payload_out_reg <= payload_out_next;
            status_reg      <= status_next;
            m_count_reg     <= m_count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_payload_out = payload_out_reg;
    assign m_status      = status_reg;
    assign m_count       = m_count_reg;

endmodule

// ===== src/idq_cell.sv =====
module idq_cell import idq_pkg::*; #(
    parameter int INDEX = 0,
    parameter int SW    = 32,
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  idq_ctrl_t        ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] pos,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [SW-1:0]    word,
    input  logic [SW-1:0]    left_data,
    input  logic [SW-1:0]    right_data,
    output logic [SW-1:0]    data,
    output logic [SW-1:0]    rd_data
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [SW-1:0] data_reg;
    logic [SW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.commit) begin
            unique case (ctrl.cmd)
                CMD_PUSH_BACK: begin
                    if (MY_CNT == count) begin
                        data_next = word;
                    end
                end
                CMD_PUSH_FRONT: begin
                    // shift toward the back, new word enters the front cell
                    data_next = (INDEX == 0) ? word : left_data;
                end
                CMD_REMOVE: begin
                    // close the gap from the removed position onward
                    if (MY_IDX >= pos) begin
                        data_next = right_data;
                    end
                end
                CMD_POP_FRONT: begin
                    data_next = right_data;
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (MY_IDX == rd_idx) ? data_reg : '0;

endmodule
